FILE: hw/rtl/neighbor_table_with_aging_core_macros.svh
// Assertion macros of the checker file of the neighbor table core.
`ifndef NEIGHBOR_TABLE_WITH_AGING_CORE_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while rst is high.
`define NTWA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("neighbor table check failed");

// Next-cycle implication, sampled on clk, muted while rst is high.
`define NTWA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("neighbor table check failed");

`endif

FILE: hw/rtl/ntwa_pkg.sv
// Package with types, sizes and codes of the neighbor table core.
package ntwa_pkg;

  localparam int MAX_NEIGHBORS = 64;
  localparam int IDX_W = $clog2(MAX_NEIGHBORS);
  localparam int CNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_BEACON  = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [1:0] CLS_MOTO  = 2'd0;
  localparam logic [1:0] CLS_LIGHT = 2'd1;
  localparam logic [1:0] CLS_HEAVY = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_CLASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] sender_id;
    logic [1:0]  sender_class;
    logic [31:0] now_ticks;
  } in_t;

  typedef struct packed {
    logic             already_known;
    logic             table_full;
    logic             evicted;
    logic [15:0]      evicted_id;
    logic [CNT_W-1:0] light_count;
    logic [CNT_W-1:0] heavy_count;
    logic [CNT_W-1:0] moto_count;
    logic [CNT_W-1:0] total_count;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  cls;
    logic [31:0] last_seen;
  } entry_t;

  // Counter update request from the sequencer.
  typedef struct packed {
    logic       inc;
    logic       dec;
    logic [1:0] cls;
  } cnt_cmd_t;

  // Reported counts, self included.
  typedef struct packed {
    logic [CNT_W-1:0] light;
    logic [CNT_W-1:0] heavy;
    logic [CNT_W-1:0] moto;
    logic [CNT_W-1:0] total;
  } cnt_rpt_t;

endpackage

FILE: hw/rtl/ntwa_counts.sv
// Entry count and per-class counters of the neighbor table.
module ntwa_counts (
  input  logic                    clk,
  input  logic                    rst,
  input  ntwa_pkg::cnt_cmd_t      cmd,
  input  logic [1:0]              own_class,
  output logic [ntwa_pkg::CNT_W-1:0] neighbor_count,
  output ntwa_pkg::cnt_rpt_t      rpt
);

  logic [ntwa_pkg::CNT_W-1:0] light_neighbors;
  logic [ntwa_pkg::CNT_W-1:0] heavy_neighbors;
  logic [ntwa_pkg::CNT_W-1:0] moto_neighbors;

  function automatic logic [ntwa_pkg::CNT_W-1:0] adj(
    input logic [ntwa_pkg::CNT_W-1:0] v, input logic up, input logic dn);
    logic [ntwa_pkg::CNT_W-1:0] r;
    r = v;
    if (up) r = v + ntwa_pkg::CNT_W'(1);
    else if (dn && v != '0) r = v - ntwa_pkg::CNT_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count  <= '0;
      light_neighbors <= '0;
      heavy_neighbors <= '0;
      moto_neighbors  <= '0;
    end else begin
      neighbor_count  <= adj(neighbor_count, cmd.inc, cmd.dec);
      light_neighbors <= adj(light_neighbors, cmd.inc && cmd.cls == ntwa_pkg::CLS_LIGHT,
                             cmd.dec && cmd.cls == ntwa_pkg::CLS_LIGHT);
      heavy_neighbors <= adj(heavy_neighbors, cmd.inc && cmd.cls == ntwa_pkg::CLS_HEAVY,
                             cmd.dec && cmd.cls == ntwa_pkg::CLS_HEAVY);
      moto_neighbors  <= adj(moto_neighbors, cmd.inc && cmd.cls == ntwa_pkg::CLS_MOTO,
                             cmd.dec && cmd.cls == ntwa_pkg::CLS_MOTO);
    end
  end

  // Add self to the class of own_class and to the total.
  assign rpt.light = light_neighbors + ntwa_pkg::CNT_W'(own_class == ntwa_pkg::CLS_LIGHT);
  assign rpt.heavy = heavy_neighbors + ntwa_pkg::CNT_W'(own_class == ntwa_pkg::CLS_HEAVY);
  assign rpt.moto  = moto_neighbors + ntwa_pkg::CNT_W'(own_class == ntwa_pkg::CLS_MOTO);
  assign rpt.total = neighbor_count + ntwa_pkg::CNT_W'(1);

endmodule

FILE: hw/rtl/neighbor_table_with_aging_core.sv
// Flow: a self beacon goes straight to the result; other items scan the listed entries in
// order until a known sender or an aged entry is found, else to the end of the list; an
// eviction then moves every later entry down one slot to close the gap.
// Throughput: one item at a time; the scan reads one entry a cycle from the two-port
// memory. A new item is taken while a result waits; its own one holds.
// Reset: rst (sync, high) empties the table and clears all counts; no clearing pass.
module neighbor_table_with_aging_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ntwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntwa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ntwa_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ntwa_pkg::out_t                 out_data
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Configuration registers.
  logic [15:0] own_id;
  logic [1:0]  own_class;
  logic [31:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id        <= '0;
      own_class     <= ntwa_pkg::CLS_LIGHT;
      timeout_ticks <= 32'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntwa_pkg::CFG_OWN_ID:    own_id <= cfg_data[15:0];
        ntwa_pkg::CFG_OWN_CLASS: own_class <= cfg_data[1:0];
        ntwa_pkg::CFG_TIMEOUT:   timeout_ticks <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Entry memory: one write port, one read port with registered data.
  ntwa_pkg::entry_t entry_mem [ntwa_pkg::MAX_NEIGHBORS];
  ntwa_pkg::entry_t rdata;
  logic                          mem_we;
  logic [ntwa_pkg::IDX_W-1:0]    mem_waddr;
  ntwa_pkg::entry_t              mem_wdata;
  logic [ntwa_pkg::IDX_W-1:0]    mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
    rdata <= entry_mem[mem_raddr];
  end

  // Counters.
  ntwa_pkg::cnt_cmd_t           cmd;
  ntwa_pkg::cnt_rpt_t           rpt;
  logic [ntwa_pkg::CNT_W-1:0]   neighbor_count;

  ntwa_counts u_counts (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .own_class      (own_class),
    .neighbor_count (neighbor_count),
    .rpt            (rpt)
  );

  // Sequencer registers.
  state_t                      state, state_next;
  ntwa_pkg::in_t               item, item_next;
  logic [ntwa_pkg::CNT_W-1:0]  rd_idx, rd_idx_next;   // next entry to read
  logic                        dv, dv_next;           // rdata holds entry chk_idx
  logic [ntwa_pkg::IDX_W-1:0]  chk_idx, chk_idx_next;
  logic                        known, known_next;
  logic                        full, full_next;
  logic                        evict, evict_next;
  logic [15:0]                 eid, eid_next;
  logic                        out_valid_next;
  ntwa_pkg::out_t              out_data_next;

  logic [31:0] age;
  logic        id_hit;
  logic        aged;

  assign mem_raddr = rd_idx[ntwa_pkg::IDX_W-1:0];
  assign age       = item.now_ticks - rdata.last_seen;
  assign id_hit    = rdata.id == item.sender_id;
  assign aged      = age > timeout_ticks;
  assign in_ready  = state == ST_IDLE;

  always_comb begin
    state_next     = state;
    item_next      = item;
    rd_idx_next    = rd_idx;
    dv_next        = dv;
    chk_idx_next   = chk_idx;
    known_next     = known;
    full_next      = full;
    evict_next     = evict;
    eid_next       = eid;
    out_valid_next = out_valid & ~out_ready;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx;
    mem_wdata      = rdata;
    cmd            = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          item_next   = in_data;
          rd_idx_next = '0;
          dv_next     = 1'b0;
          known_next  = 1'b0;
          full_next   = 1'b0;
          evict_next  = 1'b0;
          eid_next    = '0;
          // A beacon from self touches nothing.
          if (in_data.op == ntwa_pkg::OP_BEACON && in_data.sender_id == own_id) begin
            known_next = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        priority if (dv && item.op == ntwa_pkg::OP_BEACON && id_hit) begin
          // Known sender: refresh last-seen, keep id and class.
          mem_we              = 1'b1;
          mem_waddr           = chk_idx;
          mem_wdata.last_seen = item.now_ticks;
          known_next          = 1'b1;
          state_next          = ST_DONE;
        end else if (dv && item.op == ntwa_pkg::OP_TIMEOUT && aged) begin
          // Evict: drop the counts now, then move the later entries down.
          evict_next   = 1'b1;
          eid_next     = rdata.id;
          cmd.dec      = 1'b1;
          cmd.cls      = rdata.cls;
          rd_idx_next  = {1'b0, chk_idx} + ntwa_pkg::CNT_W'(1);
          dv_next      = 1'b0;
          state_next   = ST_SHIFT;
        end else if (rd_idx < neighbor_count) begin
          rd_idx_next  = rd_idx + ntwa_pkg::CNT_W'(1);
          dv_next      = 1'b1;
          chk_idx_next = rd_idx[ntwa_pkg::IDX_W-1:0];
        end else if (dv) begin
          dv_next = 1'b0;
        end else begin
          // Scan ran out without a hit.
          if (item.op == ntwa_pkg::OP_BEACON) begin
            if (neighbor_count >= ntwa_pkg::CNT_W'(ntwa_pkg::MAX_NEIGHBORS)) begin
              full_next = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = neighbor_count[ntwa_pkg::IDX_W-1:0];
              mem_wdata = '{id: item.sender_id, cls: item.sender_class,
                            last_seen: item.now_ticks};
              cmd.inc   = 1'b1;
              cmd.cls   = item.sender_class;
            end
          end
          state_next = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // Count already dropped by one, so the last source index equals it.
        if (dv) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx - ntwa_pkg::IDX_W'(1);
          mem_wdata = rdata;
        end
        priority if (rd_idx <= neighbor_count) begin
          rd_idx_next  = rd_idx + ntwa_pkg::CNT_W'(1);
          dv_next      = 1'b1;
          chk_idx_next = rd_idx[ntwa_pkg::IDX_W-1:0];
        end else if (dv) begin
          dv_next = 1'b0;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          out_valid_next              = 1'b1;
          out_data_next.already_known = known;
          out_data_next.table_full    = full;
          out_data_next.evicted       = evict;
          out_data_next.evicted_id    = eid;
          out_data_next.light_count   = rpt.light;
          out_data_next.heavy_count   = rpt.heavy;
          out_data_next.moto_count    = rpt.moto;
          out_data_next.total_count   = rpt.total;
          state_next                  = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dv        <= dv_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    rd_idx   <= rd_idx_next;
    chk_idx  <= chk_idx_next;
    known    <= known_next;
    full     <= full_next;
    evict    <= evict_next;
    eid      <= eid_next;
    out_data <= out_data_next;
  end

endmodule

FILE: hw/rtl/ntwa_checker.sv
// Port checker of the neighbor table core and its bind to the top level.
`include "neighbor_table_with_aging_core_macros.svh"

module ntwa_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ntwa_pkg::out_t out_data
);

  // A result beat waiting on the consumer holds.
  `NTWA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An accepted input beat leaves the block busy in the cycle after.
  `NTWA_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready)

  // Self is always counted.
  `NTWA_ASSERT_IMP(a_total_nonzero, out_valid, out_data.total_count != '0)

  // Beacon flags and eviction never share a result.
  `NTWA_ASSERT_IMP(a_flags_excl, out_valid,
    !(out_data.evicted && (out_data.already_known || out_data.table_full)) &&
    !(out_data.already_known && out_data.table_full))

  // No eviction means a zero id.
  `NTWA_ASSERT_IMP(a_eid_zero, out_valid && !out_data.evicted, out_data.evicted_id == '0)

endmodule

bind neighbor_table_with_aging_core ntwa_checker u_ntwa_checker (.*);

FILE: tb/neighbor_table_with_aging_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the neighbor table core: directed and random beacons and timeout checks.
module neighbor_table_with_aging_core_tb;
  import ntwa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 155;
  // More ids than table slots, so the table fills up and drops newcomers.
  localparam int POOL_SPAN = 80;
  localparam int DRAIN_CYCLES = 150;
  // Unused register index: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Mirror of the neighbor table. It predicts the count report of every accepted
  // beat and checks each result beat against the oldest prediction.
  class neighbor_tracker;
    logic [15:0] ids [MAX_NEIGHBORS];
    logic [1:0]  classes [MAX_NEIGHBORS];
    logic [31:0] seen [MAX_NEIGHBORS];
    int unsigned listed;
    int unsigned n_light;
    int unsigned n_heavy;
    int unsigned n_moto;
    logic [15:0] self_id;
    logic [1:0]  self_class;
    logic [31:0] max_age;
    out_t        due [$];
    int          errors;

    function new();
      listed = 0;
      n_light = 0;
      n_heavy = 0;
      n_moto = 0;
      self_id = '0;
      self_class = CLS_LIGHT;
      max_age = 32'd1000;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_OWN_ID:    self_id = value[15:0];
        CFG_OWN_CLASS: self_class = value[1:0];
        CFG_TIMEOUT:   max_age = value;
        default: ;
      endcase
    endfunction

    // Class "other" has no counter of its own; counters never go below zero.
    function void bump(logic [1:0] cls, bit up);
      case (cls)
        CLS_MOTO: begin
          if (up) n_moto++;
          else if (n_moto > 0) n_moto--;
        end
        CLS_LIGHT: begin
          if (up) n_light++;
          else if (n_light > 0) n_light--;
        end
        CLS_HEAVY: begin
          if (up) n_heavy++;
          else if (n_heavy > 0) n_heavy--;
        end
        default: ;
      endcase
    endfunction

    function void take_item(in_t beat);
      out_t        r;
      bit          hit;
      int          i;
      int          k;
      logic [31:0] age;
      r = '0;
      hit = 1'b0;
      if (beat.op == OP_BEACON) begin
        if (beat.sender_id == self_id) begin
          r.already_known = 1'b1;
        end else begin
          for (i = 0; i < listed && !hit; i++) begin
            if (ids[i] == beat.sender_id) begin
              seen[i] = beat.now_ticks;
              r.already_known = 1'b1;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (listed >= MAX_NEIGHBORS) begin
              r.table_full = 1'b1;
            end else begin
              ids[listed] = beat.sender_id;
              classes[listed] = beat.sender_class;
              seen[listed] = beat.now_ticks;
              listed++;
              bump(beat.sender_class, 1'b1);
            end
          end
        end
      end else begin
        for (i = 0; i < listed && !hit; i++) begin
          age = beat.now_ticks - seen[i];
          if (age > max_age) begin
            r.evicted = 1'b1;
            r.evicted_id = ids[i];
            bump(classes[i], 1'b0);
            for (k = i; k + 1 < listed; k++) begin
              ids[k] = ids[k + 1];
              classes[k] = classes[k + 1];
              seen[k] = seen[k + 1];
            end
            listed--;
            hit = 1'b1;
          end
        end
      end
      r.light_count = CNT_W'(n_light + ((self_class == CLS_LIGHT) ? 1 : 0));
      r.heavy_count = CNT_W'(n_heavy + ((self_class == CLS_HEAVY) ? 1 : 0));
      r.moto_count  = CNT_W'(n_moto + ((self_class == CLS_MOTO) ? 1 : 0));
      r.total_count = CNT_W'(listed + 1);
      due.push_back(r);
    endfunction

    function void field_cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result %h with nothing expected", $time, got);
        return;
      end
      want = due.pop_front();
      field_cmp("already_known", 32'(want.already_known), 32'(got.already_known));
      field_cmp("table_full", 32'(want.table_full), 32'(got.table_full));
      field_cmp("evicted", 32'(want.evicted), 32'(got.evicted));
      field_cmp("evicted_id", 32'(want.evicted_id), 32'(got.evicted_id));
      field_cmp("light_count", 32'(want.light_count), 32'(got.light_count));
      field_cmp("heavy_count", 32'(want.heavy_count), 32'(got.heavy_count));
      field_cmp("moto_count", 32'(want.moto_count), 32'(got.moto_count));
      field_cmp("total_count", 32'(want.total_count), 32'(got.total_count));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;

  neighbor_tracker tracker = new();
  int unsigned     cycles = 0;
  int unsigned     in_beats = 0;
  int              rx_hold = 0;
  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;
  logic [15:0]     pool_base = '0;
  logic [31:0]     clock_now = '0;

  neighbor_table_with_aging_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Sample both handshakes on the rising edge. Inputs only move on the falling
  // edge, so nothing here races against the block's own updates.
  always @(posedge clk) begin
    cycles++;
    if (!rst && in_valid && in_ready) begin
      tracker.take_item(in_data);
      in_beats++;
    end
    if (!rst && out_valid && out_ready) begin
      tracker.check_report(out_data);
      // Draw the stall that the next result beat has to sit out.
      rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold ready low until a waiting result has been stalled for the drawn count.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      if (out_valid) rx_hold--;
    end else begin
      out_ready = 1'b1;
    end
  end

  function automatic int draw_gap();
    return tx_calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic in_t pack_item(logic op, logic [15:0] id, logic [1:0] cls,
                                    logic [31:0] now);
    in_t beat;
    beat.op = op;
    beat.sender_id = id;
    beat.sender_class = cls;
    beat.now_ticks = now;
    return beat;
  endfunction

  // Present one beat after an idle gap and return on the falling edge after it
  // is taken. Valid stays high, so a back-to-back beat follows with no dip.
  task automatic send_item(input in_t beat, input int gap);
    int unsigned target;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = beat;
    in_valid = 1'b1;
    target = in_beats + 1;
    do @(negedge clk); while (in_beats < target);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_results();
    in_valid = 1'b0;
    while (tracker.due.size() != 0) @(negedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_results();
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic run_directed();
    // Empty table: a timeout check finds nothing.
    send_item(pack_item(OP_TIMEOUT, 16'hFFFF, CLS_OTHER, 32'd0), draw_gap());
    // Own id is zero after reset: self beacon.
    send_item(pack_item(OP_BEACON, 16'h0000, CLS_OTHER, 32'd0), draw_gap());
    // One entry of each class; the first is seen just before the time wraps.
    send_item(pack_item(OP_BEACON, 16'hFFFF, CLS_OTHER, 32'hFFFF_FFF0), draw_gap());
    send_item(pack_item(OP_BEACON, 16'h0001, CLS_MOTO, 32'd5), draw_gap());
    send_item(pack_item(OP_BEACON, 16'h0002, CLS_LIGHT, 32'd6), draw_gap());
    send_item(pack_item(OP_BEACON, 16'h0003, CLS_HEAVY, 32'd7), draw_gap());
    // Known sender with another class: only the last-seen time moves.
    send_item(pack_item(OP_BEACON, 16'h0001, CLS_HEAVY, 32'd8), draw_gap());
    // Age across the wrap is small: nothing ages out.
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_MOTO, 32'd100), draw_gap());
    // First entry in table order goes, though all are old.
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_MOTO, 32'h0000_1000), draw_gap());

    // Own id moved onto a listed entry; a zero timeout ages out anything not seen now.
    write_reg(CFG_OWN_ID, 32'h0000_0002);
    write_reg(CFG_OWN_CLASS, 32'(CLS_HEAVY));
    write_reg(CFG_TIMEOUT, 32'd0);
    send_item(pack_item(OP_BEACON, 16'h0002, CLS_MOTO, 32'h0000_1001), draw_gap());
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_LIGHT, 32'd8), draw_gap());
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_LIGHT, 32'd8), draw_gap());
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_LIGHT, 32'd8), draw_gap());

    // Top of every register range, plus a write to the unused index.
    write_reg(CFG_OWN_ID, 32'hFFFF_FFFF);
    write_reg(CFG_OWN_CLASS, 32'hFFFF_FFFF);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, 32'hDEAD_BEEF);
    send_item(pack_item(OP_BEACON, 16'hFFFF, CLS_LIGHT, 32'd9), draw_gap());
    send_item(pack_item(OP_TIMEOUT, 16'hFFFF, CLS_HEAVY, 32'h8000_0000), draw_gap());
    send_item(pack_item(OP_BEACON, 16'h0000, CLS_MOTO, 32'h7FFF_FFFF), draw_gap());
    send_item(pack_item(OP_BEACON, 16'hAAAA, CLS_HEAVY, 32'd0), draw_gap());
    send_item(pack_item(OP_BEACON, 16'h5555, CLS_LIGHT, 32'hFFFF_FFFF), draw_gap());

    // Half-range timeout: ages just past it get evicted.
    write_reg(CFG_OWN_CLASS, 32'(CLS_MOTO));
    write_reg(CFG_TIMEOUT, 32'h8000_0000);
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_OTHER, 32'h8000_0009), draw_gap());
    send_item(pack_item(OP_TIMEOUT, 16'h0000, CLS_OTHER, 32'h8000_0009), draw_gap());
  endtask

  // One random phase: fresh settings, then mostly in-order time with a pool of
  // ids slightly larger than the table, a little noise on top.
  task automatic run_phase(input int phase);
    logic [31:0] age_limit;
    logic [15:0] self_pick;
    logic [31:0] draw;
    int          step_max;
    int          check_pct;
    int          n;
    in_t         beat;
    if (phase % 3 == 0) pool_base = 16'($urandom);
    case (phase)
      1: age_limit = 32'd0;
      2, 5: age_limit = 32'hFFFF_FFFF;
      default: begin
        case ($urandom_range(0, 2))
          0: age_limit = $urandom_range(10, 300);
          1: age_limit = $urandom;
          default: age_limit = $urandom_range(1000, 5000);
        endcase
      end
    endcase
    case (phase)
      3: self_pick = 16'hFFFF;
      4: self_pick = 16'h0000;
      default: begin
        if ($urandom_range(0, 1) == 1)
          self_pick = 16'(pool_base + $urandom_range(0, POOL_SPAN - 1));
        else self_pick = 16'($urandom);
      end
    endcase

    // Junk in the upper bits must be masked off by the block.
    draw = $urandom;
    draw[15:0] = self_pick;
    write_reg(CFG_OWN_ID, draw);
    draw = $urandom;
    draw[1:0] = phase[1:0];
    write_reg(CFG_OWN_CLASS, draw);
    write_reg(CFG_TIMEOUT, age_limit);
    if (phase % 4 == 2) write_reg(CFG_SPARE, $urandom);

    // Every fourth phase runs both sides without any idling.
    tx_calm = (phase % 4 == 3);
    rx_calm = (phase % 4 == 3);
    step_max = (age_limit == 32'd0) ? 1 : $urandom_range(0, 40);
    check_pct = (age_limit == 32'hFFFF_FFFF) ? 5 : $urandom_range(10, 50);
    case ($urandom_range(0, 2))
      0: clock_now = $urandom;
      1: clock_now = 32'hFFFF_FFFF - $urandom_range(0, 500);
      default: ;
    endcase

    for (n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(0, 99) == 0) wait_results();
      clock_now += $urandom_range(0, step_max);
      draw = $urandom;
      beat.op = ($urandom_range(0, 99) < check_pct) ? OP_TIMEOUT : OP_BEACON;
      beat.sender_class = draw[1:0];
      case ($urandom_range(0, 19))
        0: beat.sender_id = tracker.self_id;
        1: beat.sender_id = draw[31:16];
        default: beat.sender_id = 16'(pool_base + $urandom_range(0, POOL_SPAN - 1));
      endcase
      beat.now_ticks = ($urandom_range(0, 29) == 0) ? $urandom : clock_now;
      send_item(beat, draw_gap());
    end
  endtask

  initial begin
    int phase;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    run_directed();
    // Hold off the sender once with the pipe fully drained.
    wait_results();
    for (phase = 0; phase < RANDOM_PHASES; phase++) run_phase(phase);
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
